FILE: rtl/core/hrrl_pkg.sv
`default_nettype none
package hrrl_pkg;

   // Item kinds carried in req_tuser.
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LOCATE = 1'b1;

   // Result error codes carried in rsp_tuser.
   localparam logic [1:0] ERR_OK        = 2'd0;
   localparam logic [1:0] ERR_BAD_BUILD = 2'd1;
   localparam logic [1:0] ERR_COPIES    = 2'd2;
   localparam logic [1:0] ERR_NO_NODE   = 2'd3;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] REG_RING_SIZE0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RING_SIZE1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_NODES0     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_NODES1     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BUILDS     = 3'd4;

   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 24;

   // Handshake between the top level and the search engine.
   typedef struct packed {
      logic done;
      logic fail;
   } hrrl_status_type;

endpackage
`default_nettype wire

FILE: rtl/core/hrrl_ram.sv
`default_nettype none
module hrrl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/hrrl_engine.sv
`default_nettype none
module hrrl_engine #(
   parameter int RING_ENTRIES = 1024,
   parameter int BUILD_COUNT  = 2,
   parameter int MAX_REPLICAS = 8,
   parameter int NODE_ID_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  wr_en,
   input  wire logic                                  wr_bsel,
   input  wire logic [9:0]                            wr_index,
   input  wire logic [63:0]                           wr_point,
   input  wire logic [15:0]                           wr_owner,
   input  wire logic                                  start,
   input  wire logic                                  job_bsel,
   input  wire logic [63:0]                           job_hash,
   input  wire logic [$clog2(RING_ENTRIES+1)-1:0]     job_size,
   input  wire logic [3:0]                            job_copies,
   output      hrrl_pkg::hrrl_status_type             status,
   output      logic [NODE_ID_BITS-1:0]               chosen [MAX_REPLICAS]
);

   localparam int IDX_W  = $clog2(RING_ENTRIES);
   localparam int CNT_W  = $clog2(RING_ENTRIES + 1);
   localparam int DEPTH  = BUILD_COUNT * RING_ENTRIES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CR_W   = $clog2(MAX_REPLICAS + 1);
   localparam int CI_W   = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;

   typedef enum logic [3:0] {
      E_IDLE, E_SEARCH, E_PROBE, E_LOW, E_HIGH, E_NEAR, E_OWN, E_FIRST, E_WALK
   } eng_state_type;

   eng_state_type             state_ff;
   logic [ADDR_W-1:0]         base_ff;
   logic [63:0]               hash_ff;
   logic [CNT_W-1:0]          size_ff;
   logic [3:0]                copies_ff;
   logic [IDX_W-1:0]          lo_ff, hi_ff, mid_ff, sel_ff, anchor_ff, tag_ff;
   logic [63:0]               dlo_ff, dhi_ff;
   logic [CR_W-1:0]           cnt_ff;
   logic [NODE_ID_BITS-1:0]   chosen_ff [MAX_REPLICAS];
   hrrl_pkg::hrrl_status_type status_ff;
   hrrl_pkg::hrrl_status_type status_in;

   logic                      wr_ok;
   logic [ADDR_W-1:0]         wr_addr;
   logic [63:0]               pt_data;
   logic [NODE_ID_BITS-1:0]   own_data;
   logic [ADDR_W-1:0]         pt_addr, own_addr;
   logic [IDX_W:0]            lo_sum;
   logic [IDX_W-1:0]          mid;
   logic                      gap_ok;
   logic [IDX_W-1:0]          cur_pos, nxt_pos;
   logic [IDX_W:0]            cur_inc;
   logic                      hit;
   logic                      last_copy;

   // Writes are only taken while no locate is running, so ring reads and
   // writes never meet on the same entry.
   assign wr_ok   = wr_en && (32'(wr_bsel) < BUILD_COUNT) && (32'(wr_index) < RING_ENTRIES);
   assign wr_addr = ADDR_W'(32'(wr_bsel) * RING_ENTRIES + 32'(wr_index));

   hrrl_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_point_ram (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (wr_addr),
      .wr_data (wr_point),
      .rd_addr (pt_addr),
      .rd_data (pt_data)
   );

   hrrl_ram #(.WIDTH(NODE_ID_BITS), .DEPTH(DEPTH)) u_owner_ram (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (wr_addr),
      .wr_data (NODE_ID_BITS'(wr_owner)),
      .rd_addr (own_addr),
      .rd_data (own_data)
   );

   always_comb begin
      lo_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
      mid     = lo_sum[IDX_W:1];
      gap_ok  = ({1'b0, lo_ff} + 1'b1) < {1'b0, hi_ff};
      cur_pos = (state_ff == E_WALK) ? tag_ff : sel_ff;
      cur_inc = {1'b0, cur_pos} + 1'b1;
      nxt_pos = (32'(cur_inc) == 32'(size_ff)) ? '0 : cur_inc[IDX_W-1:0];
      if (state_ff == E_SEARCH) begin
         pt_addr = base_ff + ADDR_W'(gap_ok ? mid : lo_ff);
      end else begin
         pt_addr = base_ff + ADDR_W'(hi_ff);
      end
      own_addr = base_ff + ADDR_W'((state_ff == E_OWN) ? sel_ff : nxt_pos);
      hit = 1'b0;
      for (int j = 0; j < MAX_REPLICAS; j++) begin
         if ((CR_W'(j) < cnt_ff) && (chosen_ff[j] == own_data)) begin
            hit = 1'b1;
         end
      end
      last_copy = (8'(cnt_ff) + 8'd1) == 8'(copies_ff);
      status_in = '0;
      if ((state_ff == E_FIRST) && (copies_ff == 4'd1)) begin
         status_in = '{done: 1'b1, fail: 1'b0};
      end
      if (state_ff == E_WALK) begin
         if (tag_ff == anchor_ff) begin
            status_in = '{done: 1'b1, fail: 1'b1};
         end else if (!hit && last_copy) begin
            status_in = '{done: 1'b1, fail: 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= E_IDLE;
         status_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         status_ff <= status_in;
         unique case (state_ff)
            E_IDLE: begin
               if (start) begin
                  base_ff   <= ADDR_W'(32'(job_bsel) * RING_ENTRIES);
                  hash_ff   <= job_hash;
                  size_ff   <= job_size;
                  copies_ff <= job_copies;
                  lo_ff     <= '0;
                  hi_ff     <= IDX_W'(job_size - 1'b1);
                  state_ff  <= E_SEARCH;
               end
            end
            E_SEARCH: begin
               mid_ff   <= mid;
               state_ff <= gap_ok ? E_PROBE : E_LOW;
            end
            E_PROBE: begin
               if (hash_ff == pt_data) begin
                  sel_ff   <= mid_ff;
                  state_ff <= E_OWN;
               end else begin
                  if (hash_ff < pt_data) begin
                     hi_ff <= mid_ff;
                  end else begin
                     lo_ff <= mid_ff;
                  end
                  state_ff <= E_SEARCH;
               end
            end
            E_LOW: begin
               dlo_ff   <= hash_ff - pt_data;
               state_ff <= E_HIGH;
            end
            E_HIGH: begin
               dhi_ff   <= pt_data - hash_ff;
               state_ff <= E_NEAR;
            end
            E_NEAR: begin
               // A tie goes to the lower bracketing point.
               sel_ff   <= (dlo_ff > dhi_ff) ? hi_ff : lo_ff;
               state_ff <= E_OWN;
            end
            E_OWN: begin
               state_ff <= E_FIRST;
            end
            E_FIRST: begin
               chosen_ff[0] <= own_data;
               anchor_ff    <= sel_ff;
               cnt_ff       <= CR_W'(1);
               tag_ff       <= nxt_pos;
               if (copies_ff == 4'd1) begin
                  state_ff <= E_IDLE;
               end else begin
                  state_ff <= E_WALK;
               end
            end
            E_WALK: begin
               // One owner read is issued per cycle; the walk ends on a miss
               // when it comes back around to the last chosen point.
               tag_ff <= nxt_pos;
               if (tag_ff == anchor_ff) begin
                  state_ff <= E_IDLE;
               end else if (!hit) begin
                  chosen_ff[cnt_ff[CI_W-1:0]] <= own_data;
                  anchor_ff <= tag_ff;
                  cnt_ff    <= cnt_ff + 1'b1;
                  if (last_copy) begin
                     state_ff <= E_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= E_IDLE;
            end
         endcase
      end
   end

   assign status = status_ff;
   assign chosen = chosen_ff;

endmodule
`default_nettype wire

FILE: rtl/core/hash_ring_replica_locator.sv
`default_nettype none
// A locate runs a binary search over the point memory, then a replica walk over the owner
// memory, then plays out its result beats; the walk length depends on the data and can reach
// the ring size for each replica. One item is worked on at a time.
// Reset is synchronous and active high; it restores the configuration registers and control
// state. The ring memories are not cleared and hold undefined data until written.
module hash_ring_replica_locator #(
   parameter int RING_ENTRIES = 1024,
   parameter int BUILD_COUNT  = 2,
   parameter int MAX_REPLICAS = 8,
   parameter int NODE_ID_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   // tdata: build_sel, entry_index, entry_point, entry_owner, key_hash, copies_wanted, pad.
   input  wire logic [hrrl_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: func.
   input  wire logic                                 req_tuser,
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // tdata: owner_id, replica_pos, pad.
   output      logic [hrrl_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // tlast: last_of_run.
   output      logic                                 rsp_tlast,
   // tuser: error_code.
   output      logic [1:0]                           rsp_tuser,
   input  wire logic                                 csr_we,
   input  wire logic [hrrl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [hrrl_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CNT_W = $clog2(RING_ENTRIES + 1);
   localparam int CR_W  = $clog2(MAX_REPLICAS + 1);
   localparam int CI_W  = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} top_state_type;

   // Request fields, unpacked from the beat.
   logic        f_bsel;
   logic [9:0]  f_index;
   logic [63:0] f_point;
   logic [15:0] f_owner;
   logic [63:0] f_hash;
   logic [3:0]  f_copies;

   assign f_bsel   = req_tdata[0];
   assign f_index  = req_tdata[10:1];
   assign f_point  = req_tdata[74:11];
   assign f_owner  = req_tdata[90:75];
   assign f_hash   = req_tdata[154:91];
   assign f_copies = req_tdata[158:155];

   // Configuration registers.
   logic [10:0] size0_ff, size1_ff, nodes0_ff, nodes1_ff;
   logic [1:0]  builds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size0_ff  <= 11'd1;
         size1_ff  <= 11'd1;
         nodes0_ff <= '0;
         nodes1_ff <= '0;
         builds_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            hrrl_pkg::REG_RING_SIZE0: size0_ff  <= csr_wdata;
            hrrl_pkg::REG_RING_SIZE1: size1_ff  <= csr_wdata;
            hrrl_pkg::REG_NODES0:     nodes0_ff <= csr_wdata;
            hrrl_pkg::REG_NODES1:     nodes1_ff <= csr_wdata;
            hrrl_pkg::REG_BUILDS:     builds_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   top_state_type             state_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [15:0]               owner_ff;
   logic [2:0]                pos_ff;
   logic                      last_ff;
   logic [1:0]                err_ff;
   logic [3:0]                copies_ff;
   logic [CR_W-1:0]           k_ff;
   logic [1:0]                pend_err_ff;

   hrrl_pkg::hrrl_status_type eng_status;
   logic [NODE_ID_BITS-1:0]   chosen [MAX_REPLICAS];

   logic        slot_free;
   logic        accept;
   logic        bad_build;
   logic        bad_copies;
   logic        start;
   logic [10:0] size_sel, nodes_sel;
   logic [CNT_W-1:0] job_size;
   logic        emit_last;
   logic        load_beat;

   // The result register frees when its beat is taken, so the next item can
   // be accepted in the same cycle.
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      size_sel   = f_bsel ? size1_ff : size0_ff;
      nodes_sel  = f_bsel ? nodes1_ff : nodes0_ff;
      bad_build  = (32'(f_bsel) >= BUILD_COUNT) || ({1'b0, f_bsel} >= builds_ff);
      bad_copies = (f_copies == 4'd0) || (11'(f_copies) > nodes_sel)
                   || (32'(f_copies) > MAX_REPLICAS);
      // A zero ring size counts as one, and a size beyond the ring as the ring.
      if (size_sel == 11'd0) begin
         job_size = CNT_W'(1);
      end else if (32'(size_sel) > RING_ENTRIES) begin
         job_size = CNT_W'(RING_ENTRIES);
      end else begin
         job_size = CNT_W'(size_sel);
      end
      start     = accept && (req_tuser == hrrl_pkg::FUNC_LOCATE) && !bad_build && !bad_copies;
      emit_last = (8'(k_ff) + 8'd1) == 8'(copies_ff);
      // A new beat is loaded for an early error answer or for each emitted result;
      // otherwise the valid flag drops once the receiver has taken the beat.
      load_beat = ((state_ff == ST_IDLE) && accept && (req_tuser == hrrl_pkg::FUNC_LOCATE)
                   && (bad_build || bad_copies)) || ((state_ff == ST_EMIT) && slot_free);
      rsp_valid_in = load_beat || (rsp_valid_ff && !rsp_tready);
   end

   hrrl_engine #(
      .RING_ENTRIES (RING_ENTRIES),
      .BUILD_COUNT  (BUILD_COUNT),
      .MAX_REPLICAS (MAX_REPLICAS),
      .NODE_ID_BITS (NODE_ID_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (accept && (req_tuser == hrrl_pkg::FUNC_WRITE)),
      .wr_bsel    (f_bsel),
      .wr_index   (f_index),
      .wr_point   (f_point),
      .wr_owner   (f_owner),
      .start      (start),
      .job_bsel   (f_bsel),
      .job_hash   (f_hash),
      .job_size   (job_size),
      .job_copies (f_copies),
      .status     (eng_status),
      .chosen     (chosen)
   );

   // Control sequencer: a locate either answers at once with an error beat or runs the engine,
   // then plays out the chosen owners one beat at a time, or one error beat when the walk fails.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_tuser == hrrl_pkg::FUNC_LOCATE)) begin
                  copies_ff <= f_copies;
                  if (bad_build || bad_copies) begin
                     owner_ff <= '0;
                     pos_ff   <= '0;
                     last_ff  <= 1'b1;
                     err_ff   <= bad_build ? hrrl_pkg::ERR_BAD_BUILD : hrrl_pkg::ERR_COPIES;
                  end else begin
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_RUN: begin
               if (eng_status.done) begin
                  pend_err_ff <= eng_status.fail ? hrrl_pkg::ERR_NO_NODE : hrrl_pkg::ERR_OK;
                  k_ff        <= '0;
                  state_ff    <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (slot_free) begin
                  if (pend_err_ff != hrrl_pkg::ERR_OK) begin
                     owner_ff <= '0;
                     pos_ff   <= '0;
                     last_ff  <= 1'b1;
                     err_ff   <= pend_err_ff;
                     state_ff <= ST_IDLE;
                  end else begin
                     owner_ff <= 16'(chosen[k_ff[CI_W-1:0]]);
                     pos_ff   <= 3'(k_ff);
                     last_ff  <= emit_last;
                     err_ff   <= hrrl_pkg::ERR_OK;
                     k_ff     <= k_ff + 1'b1;
                     if (emit_last) begin
                        state_ff <= ST_IDLE;
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, pos_ff, owner_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = err_ff;

endmodule
`default_nettype wire
